// File: rtl/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg
// Shared types and constants of the chamfer 2-3 nearest feature map.
// ----------------------------------------------------------------------------
`default_nettype none
package cfm_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_COMP = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDW,
		ST_SCAN,
		ST_FWD,
		ST_BWD,
		ST_DONE
	} state_t;

	localparam logic        CFG_WIDTH     = 1'b0;
	localparam logic        CFG_HEIGHT    = 1'b1;
	localparam logic [15:0] NO_FEATURE    = 16'd60000;
	localparam logic [16:0] STEP_STRAIGHT = 17'd2;
	localparam logic [16:0] STEP_DIAG     = 17'd3;
	localparam logic [2:0]  PH_ME         = 3'd0;
	localparam logic [2:0]  PH_LAST       = 3'd5;

endpackage
`default_nettype wire

// File: rtl/cfm_req_if.sv
// ----------------------------------------------------------------------------
// cfm_req_if
// Request channel: load, compute or read of one pixel.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] pix_x;
	logic [7:0] pix_y;
	logic       feature;

	modport source (output valid, req_type, pix_x, pix_y, feature, input ready);
	modport sink (input valid, req_type, pix_x, pix_y, feature, output ready);
endinterface
`default_nettype wire

// File: rtl/cfm_res_if.sv
// ----------------------------------------------------------------------------
// cfm_res_if
// Result channel: distance, nearest feature and pass flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] dist_res;
	logic [7:0]  near_x;
	logic [7:0]  near_y;
	logic        found_any;
	logic        all_feature;

	modport source (output valid, dist_res, near_x, near_y, found_any, all_feature,
		input ready);
	modport sink (input valid, dist_res, near_x, near_y, found_any, all_feature,
		output ready);
endinterface
`default_nettype wire

// File: rtl/chamfer32_nearest_feature_map.sv
// ----------------------------------------------------------------------------
// chamfer32_nearest_feature_map
// Chamfer 2-3 distance transform with nearest feature coordinates.
// ----------------------------------------------------------------------------
// Usage: words arrive on req (valid/ready), results leave on res.
// A load word writes one pixel and gives no result; loads stream one per cycle
// while idle. A read word returns its result via the memory read register and
// then the result register. A compute word sweeps the image once to test for
// an all-feature image, then, unless every pixel is a feature, runs a forward
// and a backward pass; there each pixel takes an own read, four neighbor reads
// and a write in turn, set by the single read port of the pixel memory.
// One result register sits on res: loads are still taken while it waits;
// reads and computes wait until it drains. While busy, req.ready is low.
// Reset clears the flags (found_any 0, all_feature 1) and sets the image
// size to 256x256; the pixel memory is not cleared, every pixel in use must
// be loaded before compute or read. Image size writes go on cfg while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module chamfer32_nearest_feature_map #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [8:0] cfg_data,
	cfm_req_if.sink         req,
	cfm_res_if.source       res
);
	import cfm_pkg::*;

	localparam int WCAP  = (MAX_WIDTH > 256) ? 256 : MAX_WIDTH;
	localparam int HCAP  = (MAX_HEIGHT > 256) ? 256 : MAX_HEIGHT;
	localparam int AXW   = $clog2(WCAP);
	localparam int AYW   = $clog2(HCAP);
	localparam int AW    = AXW + AYW;
	localparam int DEPTH = 1 << AW;
	localparam logic [8:0] WCAP9 = 9'(WCAP);
	localparam logic [8:0] HCAP9 = 9'(HCAP);

	state_t st_q, st_d;

	logic [8:0]  img_w_q, img_h_q;
	logic [8:0]  weff, heff;
	logic [7:0]  wlast, hlast;

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] raddr, waddr;
	logic        we;
	logic [31:0] wdata;
	logic [15:0] rd_d;
	logic [7:0]  rd_x, rd_y;

	logic [7:0]  cx_q, cy_q;
	logic [2:0]  ph_q;
	logic        scan_done_q, scan_v_s1, scan_last_s1;
	logic        found_q, full_q;
	logic [15:0] cur_d_q;
	logic [7:0]  cur_x_q, cur_y_q;
	logic        nb_ok_s1;
	logic [16:0] step_s1;
	logic        rd_in_q;
	logic [7:0]  rd_px_q, rd_py_q;

	logic        ov_q;
	logic [15:0] o_d_q;
	logic [7:0]  o_x_q, o_y_q;
	logic        o_f_q, o_a_q;

	logic        in_acc, in_ok, full_now, scan_end, pix_last_f, pix_last_b;
	logic [1:0]  nk;
	logic        nb_ok;
	logic [7:0]  nbx, nby;
	logic [16:0] cand;
	logic        upd;
	logic [15:0] nd;
	logic [7:0]  nx_n, ny_n;

	function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
		return {y[AYW-1:0], x[AXW-1:0]};
	endfunction

	// effective image size
	always_comb begin
		if (img_w_q == 9'd0) weff = 9'd1;
		else if (img_w_q > WCAP9) weff = WCAP9;
		else weff = img_w_q;
		if (img_h_q == 9'd0) heff = 9'd1;
		else if (img_h_q > HCAP9) heff = HCAP9;
		else heff = img_h_q;
	end
	assign wlast = 8'(weff - 9'd1);
	assign hlast = 8'(heff - 9'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= 9'd256;
			img_h_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDTH:  img_w_q <= cfg_data;
				CFG_HEIGHT: img_h_q <= cfg_data;
				default:    img_w_q <= img_w_q;
			endcase
		end
	end

	assign in_acc = req.valid && req.ready;
	assign in_ok  = (req.pix_x <= wlast) && (req.pix_y <= hlast);
	assign rd_d   = rd_q[31:16];
	assign rd_x   = rd_q[15:8];
	assign rd_y   = rd_q[7:0];
	assign full_now   = full_q && (rd_d == 16'd0);
	assign scan_end   = (cx_q == wlast) && (cy_q == hlast);
	assign pix_last_f = scan_end;
	assign pix_last_b = (cx_q == 8'd0) && (cy_q == 8'd0);

	// neighbor for issue phases one to four
	assign nk = 2'(ph_q - 3'd1);
	always_comb begin
		nbx   = cx_q;
		nby   = cy_q;
		nb_ok = 1'b0;
		if (st_q == ST_FWD) begin
			unique case (nk)
				2'd0: begin nbx = cx_q - 8'd1; nb_ok = (cx_q != 8'd0); end
				2'd1: begin nby = cy_q - 8'd1; nb_ok = (cy_q != 8'd0); end
				2'd2: begin
					nbx = cx_q - 8'd1; nby = cy_q - 8'd1;
					nb_ok = (cx_q != 8'd0) && (cy_q != 8'd0);
				end
				default: begin
					nbx = cx_q + 8'd1; nby = cy_q - 8'd1;
					nb_ok = (cx_q != wlast) && (cy_q != 8'd0);
				end
			endcase
		end else begin
			unique case (nk)
				2'd0: begin nbx = cx_q + 8'd1; nb_ok = (cx_q != wlast); end
				2'd1: begin nby = cy_q + 8'd1; nb_ok = (cy_q != hlast); end
				2'd2: begin
					nbx = cx_q + 8'd1; nby = cy_q + 8'd1;
					nb_ok = (cx_q != wlast) && (cy_q != hlast);
				end
				default: begin
					nbx = cx_q - 8'd1; nby = cy_q + 8'd1;
					nb_ok = (cx_q != 8'd0) && (cy_q != hlast);
				end
			endcase
		end
	end

	// one relaxation step against the neighbor word just read
	assign cand = {1'b0, rd_d} + step_s1;
	assign upd  = nb_ok_s1 && ({1'b0, cur_d_q} > cand);
	assign nd   = upd ? cand[15:0] : cur_d_q;
	assign nx_n = upd ? rd_x : cur_x_q;
	assign ny_n = upd ? rd_y : cur_y_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority case (req_t'(req.req_type))
						REQ_COMP: st_d = ST_SCAN;
						REQ_READ: st_d = ST_RDW;
						default:  st_d = ST_IDLE;
					endcase
				end
			end
			ST_RDW:  st_d = ST_IDLE;
			ST_SCAN: if (scan_last_s1) st_d = full_now ? ST_DONE : ST_FWD;
			ST_FWD:  if (ph_q == PH_LAST && pix_last_f) st_d = ST_BWD;
			ST_BWD:  if (ph_q == PH_LAST && pix_last_b) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine: handshake and memory ports
	always_comb begin
		req.ready = 1'b0;
		raddr     = addr_of(cx_q, cy_q);
		we        = 1'b0;
		waddr     = addr_of(cx_q, cy_q);
		wdata     = {nd, nx_n, ny_n};
		unique case (st_q)
			ST_IDLE: begin
				req.ready = (req.req_type == REQ_LOAD) || (req.req_type == REQ_NONE)
					|| !ov_q || res.ready;
				raddr = addr_of(req.pix_x, req.pix_y);
				waddr = addr_of(req.pix_x, req.pix_y);
				we    = in_acc && (req.req_type == REQ_LOAD) && in_ok;
				wdata = {(req.feature ? 16'd0 : NO_FEATURE), req.pix_x, req.pix_y};
			end
			ST_FWD, ST_BWD: begin
				if (ph_q != PH_ME) raddr = addr_of(nbx, nby);
				we = (ph_q == PH_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cx_q         <= 8'd0;
			cy_q         <= 8'd0;
			ph_q         <= PH_ME;
			scan_done_q  <= 1'b0;
			scan_v_s1    <= 1'b0;
			scan_last_s1 <= 1'b0;
			found_q      <= 1'b0;
			full_q       <= 1'b1;
			ov_q         <= 1'b0;
			nb_ok_s1     <= 1'b0;
			step_s1      <= STEP_STRAIGHT;
			cur_d_q      <= 16'd0;
			cur_x_q      <= 8'd0;
			cur_y_q      <= 8'd0;
		end else begin
			st_q <= st_d;
			if (res.valid && res.ready) ov_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			scan_last_s1 <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && req.req_type == REQ_COMP) begin
						cx_q        <= 8'd0;
						cy_q        <= 8'd0;
						scan_done_q <= 1'b0;
						found_q     <= 1'b0;
						full_q      <= 1'b1;
					end
				end
				ST_RDW: ov_q <= 1'b1;
				ST_SCAN: begin
					if (!scan_done_q) begin
						scan_v_s1    <= 1'b1;
						scan_last_s1 <= scan_end;
						if (scan_end) scan_done_q <= 1'b1;
						else if (cx_q == wlast) begin
							cx_q <= 8'd0;
							cy_q <= cy_q + 8'd1;
						end else cx_q <= cx_q + 8'd1;
					end
					if (scan_v_s1 && rd_d != 16'd0) full_q <= 1'b0;
					if (scan_last_s1) begin
						if (full_now) found_q <= 1'b1;
						cx_q <= 8'd0;
						cy_q <= 8'd0;
						ph_q <= PH_ME;
					end
				end
				ST_FWD, ST_BWD: begin
					if (ph_q == PH_LAST) ph_q <= PH_ME;
					else ph_q <= ph_q + 3'd1;
					if (ph_q != PH_ME && ph_q != PH_LAST) begin
						nb_ok_s1 <= nb_ok;
						step_s1  <= (nk[1] == 1'b0) ? STEP_STRAIGHT : STEP_DIAG;
					end
					if (ph_q == 3'd1) begin
						cur_d_q <= rd_d;
						cur_x_q <= rd_x;
						cur_y_q <= rd_y;
					end else if (ph_q != PH_ME) begin
						cur_d_q <= nd;
						cur_x_q <= nx_n;
						cur_y_q <= ny_n;
						if (upd) found_q <= 1'b1;
					end
					if (ph_q == PH_LAST) begin
						if (st_q == ST_FWD) begin
							if (pix_last_f) begin
								cx_q <= wlast;
								cy_q <= hlast;
							end else if (cx_q == wlast) begin
								cx_q <= 8'd0;
								cy_q <= cy_q + 8'd1;
							end else cx_q <= cx_q + 8'd1;
						end else begin
							if (cx_q == 8'd0) begin
								cx_q <= wlast;
								cy_q <= cy_q - 8'd1;
							end else cx_q <= cx_q - 8'd1;
						end
					end
				end
				ST_DONE: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result register payload and read bookkeeping
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_acc) begin
			rd_in_q <= in_ok;
			rd_px_q <= req.pix_x;
			rd_py_q <= req.pix_y;
		end
		if (st_q == ST_RDW) begin
			o_d_q <= rd_in_q ? rd_d : NO_FEATURE;
			o_x_q <= rd_in_q ? rd_x : rd_px_q;
			o_y_q <= rd_in_q ? rd_y : rd_py_q;
			o_f_q <= found_q;
			o_a_q <= full_q;
		end else if (st_q == ST_DONE) begin
			o_d_q <= 16'd0;
			o_x_q <= 8'd0;
			o_y_q <= 8'd0;
			o_f_q <= found_q;
			o_a_q <= full_q;
		end
	end

	assign res.valid       = ov_q;
	assign res.dist_res    = o_d_q;
	assign res.near_x      = o_x_q;
	assign res.near_y      = o_y_q;
	assign res.found_any   = o_f_q;
	assign res.all_feature = o_a_q;

	// no memory write while the full-image test sweeps
	a_scan_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> !we)
		else $error("write during scan");

	// an all-feature image always reports found
	a_full_found: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && full_q) |-> found_q)
		else $error("all_feature without found_any");

	// a result is only produced once the result register is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RDW || st_q == ST_DONE) |-> (!ov_q || res.ready))
		else $error("result register overrun");

	// the forward pass leaves by way of a full pixel step
	a_pass_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FWD && st_d == ST_BWD) |-> (ph_q == PH_LAST && we))
		else $error("forward pass left early");

endmodule
`default_nettype wire
